// ===== rtl/bblru_pkg.sv =====
// Shared types and constants for the byte-budget LRU cache.
// Used by bblru_cell and byte_budget_lru_cache; depends on nothing.
`default_nettype none

package bblru_pkg;

    // Field widths of the request and result items
    localparam int KEY_FIELD_W  = 32;
    localparam int BYTES_W      = 32;
    localparam int TOTAL_W      = BYTES_W + 1;
    localparam int EVICT_W      = 5;
    localparam int S_TDATA_W    = KEY_FIELD_W + BYTES_W;
    localparam int M_TDATA_W    = 40;

    // Parameter defaults
    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 32;

    // Operation broadcast to every cell in the chain
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_MATCH,
        CELL_EVICT,
        CELL_MOVE,
        CELL_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t             op;
        logic [BYTES_W-1:0]   new_bytes;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/bblru_cell.sv =====
// One position of the recency chain: holds the key, size and valid bit of
// the entry at that age. Depends on bblru_pkg.
`default_nettype none

module bblru_cell
    import bblru_pkg::*;
#(
    parameter int KW = KEY_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cell_cmd_t          cmd,
    input  wire logic [KW-1:0]      new_key,
    input  wire logic [KW-1:0]      right_key,
    input  wire logic [BYTES_W-1:0] right_bytes,
    input  wire logic               right_valid,
    input  wire logic               left_valid,
    input  wire logic               seen_in,
    output logic [KW-1:0]           key,
    output logic [BYTES_W-1:0]      bytes,
    output logic                    valid,
    output logic                    match,
    output logic                    seen_out
);

    logic [KW-1:0]      key_reg, key_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic               valid_reg, valid_next;
    logic               match_reg, match_next;
    logic               seen_here;

    // A hit at this position or any older one shifts this cell
    assign seen_here = seen_in | match_reg;
    assign seen_out  = seen_here;

    always_comb
    begin
        key_next   = key_reg;
        bytes_next = bytes_reg;
        valid_next = valid_reg;
        match_next = match_reg;
        unique case (cmd.op)
            CELL_HOLD:
            begin
            end
            CELL_MATCH:
            begin
                match_next = valid_reg && (key_reg == new_key);
            end
            CELL_EVICT:
            begin
                // advance the younger neighbor into this position
                key_next   = right_key;
                bytes_next = right_bytes;
                valid_next = right_valid;
            end
            CELL_MOVE:
            begin
                if (seen_here && valid_reg)
                begin
                    if (right_valid)
                    begin
                        key_next   = right_key;
                        bytes_next = right_bytes;
                    end
                    else
                    begin
                        // youngest valid position takes the hit entry
                        key_next   = new_key;
                        bytes_next = cmd.new_bytes;
                    end
                end
            end
            CELL_INSERT:
            begin
                if (!valid_reg && left_valid)
                begin
                    key_next   = new_key;
                    bytes_next = cmd.new_bytes;
                    valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold payload without reset
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        bytes_reg <= bytes_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    assign key   = key_reg;
    assign bytes = bytes_reg;
    assign valid = valid_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

// ===== rtl/byte_budget_lru_cache.sv =====
// Top level of the byte-budget LRU cache: request/result stream ports,
// sequencer and total-bytes counter. Depends on bblru_pkg and bblru_cell.
//
// Usage:
//   A request on the s_ side carries an object key and its size in bytes.
//   The cache looks the key up in a row of ENTRIES cells kept in age order,
//   oldest in cell 0. A hit moves the entry to the young end; a miss inserts
//   it if it fits the budget (evicting the oldest first when the table is
//   full), then evicts oldest entries until the held bytes fit the budget.
//   One result per request leaves on the m_ side: hit, inserted, number of
//   entries evicted, and bytes in use afterwards.
//   Steps: a hit goes through match, decide and move; a miss goes through
//   match, decide, an eviction of the oldest entry when the table is full,
//   insert if it fits, then trim evictions (up to ENTRIES in all). One
//   request is in work at a time and the next is taken in the cycle after
//   the result loads, so the eviction sweep sets the rate.
//   The result sits in an output register; s_tready returns as soon as the
//   result is loaded, so a new request is taken while the result waits.
//   A stalled receiver holds the result and, once a second result is ready,
//   holds the sequencer until the first is taken.
//   Reset empties the cache, clears the byte count and sets the budget to 0.
//   Write byte_budget through cfg_wen/cfg_wdata only while the block is idle.
`default_nettype none

module byte_budget_lru_cache
    import bblru_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wen,
    input  wire logic [BYTES_W-1:0]   cfg_wdata,     // byte_budget
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,       // [31:0] object_key, [63:32] object_bytes
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata        // [0] hit, [1] inserted,
                                                     // [6:2] evicted_count,
                                                     // [38:7] bytes_in_use, [39] zero
);

    localparam int KW    = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_DECIDE,
        ST_MOVE,
        ST_FULL_EVICT,
        ST_INSERT,
        ST_TRIM,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [BYTES_W-1:0]   budget_reg;
    logic [KW-1:0]        req_key_reg;
    logic [BYTES_W-1:0]   req_bytes_reg;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 hit_reg, hit_next;
    logic                 ins_reg, ins_next;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    cell_cmd_t            cmd;
    logic [KW-1:0]        key_arr   [ENTRIES];
    logic [BYTES_W-1:0]   bytes_arr [ENTRIES];
    logic [ENTRIES-1:0]   valid_vec;
    logic [ENTRIES-1:0]   match_vec;
    logic [ENTRIES-1:0]   seen_vec;
    logic [BYTES_W-1:0]   hit_bytes;
    logic                 over_budget;
    logic                 fits;
    logic                 out_free;
    logic                 accept;

    // Chain of cells, oldest at index 0
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        logic [KW-1:0]      r_key;
        logic [BYTES_W-1:0] r_bytes;
        logic               r_valid;
        logic               l_valid;
        logic               s_in;

        if (i == ENTRIES - 1)
        begin : g_last
            assign r_key   = '0;
            assign r_bytes = '0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_mid
            assign r_key   = key_arr[i+1];
            assign r_bytes = bytes_arr[i+1];
            assign r_valid = valid_vec[i+1];
        end

        if (i == 0)
        begin : g_first
            assign l_valid = 1'b1;
            assign s_in    = 1'b0;
        end
        else
        begin : g_rest
            assign l_valid = valid_vec[i-1];
            assign s_in    = seen_vec[i-1];
        end

        bblru_cell #(
            .KW (KW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .new_key     (req_key_reg),
            .right_key   (r_key),
            .right_bytes (r_bytes),
            .right_valid (r_valid),
            .left_valid  (l_valid),
            .seen_in     (s_in),
            .key         (key_arr[i]),
            .bytes       (bytes_arr[i]),
            .valid       (valid_vec[i]),
            .match       (match_vec[i]),
            .seen_out    (seen_vec[i])
        );
    end

    // Select the size of the hit entry
    always_comb
    begin
        hit_bytes = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_bytes = hit_bytes | (bytes_arr[i] & {BYTES_W{match_vec[i]}});
        end
    end

    assign over_budget = total_reg > {1'b0, budget_reg};
    assign fits        = req_bytes_reg <= budget_reg;
    assign out_free    = !m_valid_reg || m_tready;
    assign s_tready    = (state_reg == ST_IDLE);
    assign accept      = s_tvalid && s_tready;

    // Sequence one request through the chain
    always_comb
    begin
        state_next    = state_reg;
        total_next    = total_reg;
        cnt_next      = cnt_reg;
        hit_next      = hit_reg;
        ins_next      = ins_reg;
        cmd.op        = CELL_HOLD;
        cmd.new_bytes = req_bytes_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next   = '0;
                    hit_next   = 1'b0;
                    ins_next   = 1'b0;
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                cmd.op     = CELL_MATCH;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (|match_vec)
                begin
                    hit_next   = 1'b1;
                    state_next = ST_MOVE;
                end
                else if (fits)
                begin
                    state_next = valid_vec[ENTRIES-1] ? ST_FULL_EVICT : ST_INSERT;
                end
                else
                begin
                    state_next = ST_TRIM;
                end
            end
            ST_MOVE:
            begin
                cmd.op        = CELL_MOVE;
                cmd.new_bytes = hit_bytes;
                state_next    = ST_DONE;
            end
            ST_FULL_EVICT:
            begin
                cmd.op     = CELL_EVICT;
                total_next = total_reg - TOTAL_W'(bytes_arr[0]);
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                cmd.op     = CELL_INSERT;
                total_next = total_reg + TOTAL_W'(req_bytes_reg);
                ins_next   = 1'b1;
                state_next = ST_TRIM;
            end
            ST_TRIM:
            begin
                if (over_budget && valid_vec[0])
                begin
                    cmd.op     = CELL_EVICT;
                    total_next = total_reg - TOTAL_W'(bytes_arr[0]);
                    cnt_next   = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold request payload and load the result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_key_reg   <= s_tdata[KW-1:0];
            req_bytes_reg <= s_tdata[KEY_FIELD_W +: BYTES_W];
        end
        if (state_reg == ST_DONE && out_free)
        begin
            m_data_reg <= {1'b0, total_reg[BYTES_W-1:0], EVICT_W'(cnt_reg), ins_reg, hit_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            budget_reg  <= '0;
            total_reg   <= '0;
            cnt_reg     <= '0;
            hit_reg     <= 1'b0;
            ins_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            cnt_reg   <= cnt_next;
            hit_reg   <= hit_next;
            ins_reg   <= ins_next;
            if (cfg_wen)
            begin
                budget_reg <= cfg_wdata;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Valid entries stay packed at the old end of the chain
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, valid_vec} + {{ENTRIES{1'b0}}, 1'b1}))
        else $error("valid cells not contiguous from the oldest end");

    // Keys are unique, so at most one cell matches
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) |-> $onehot0(match_vec))
        else $error("more than one cell matched the request key");

    // A finished miss leaves the cache within budget
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !hit_reg) |-> !over_budget)
        else $error("bytes in use above budget after a miss");

    // Evictions per request never exceed the entry count
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(ENTRIES))
        else $error("eviction count out of range");

    // An empty cache holds no bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (!valid_vec[0] && state_reg == ST_DONE) |-> (total_reg == '0))
        else $error("byte count nonzero with an empty cache");

endmodule

`default_nettype wire

// ===== sim/bblru_result_monitor.sv =====
// Result monitor for the byte-budget LRU cache: watches the config, request and
// result channels, predicts each result and compares it field by field.
// Depends on bblru_pkg for field widths and the default entry count.
`default_nettype none

module bblru_result_monitor
    import bblru_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wen,
    input  wire logic [BYTES_W-1:0]   cfg_wdata,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,     // [31:0] object_key, [63:32] object_bytes
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,     // [0] hit, [1] inserted,
                                                   // [6:2] evicted_count,
                                                   // [38:7] bytes_in_use
    output int                        fail_count,
    output int                        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [KEY_FIELD_W-1:0] key;
        logic [BYTES_W-1:0]     size;
    } held_obj_t;

    typedef struct packed {
        logic               hit;
        logic               inserted;
        logic [EVICT_W-1:0] evicted;
        logic [BYTES_W-1:0] in_use;
    } lookup_result_t;

    // Cached objects, oldest first
    held_obj_t          age_list[$];
    lookup_result_t     results_due[$];
    logic [BYTES_W-1:0] budget;
    logic [TOTAL_W-1:0] held_bytes;

    // Remove the least recently used object and its bytes
    function automatic void drop_oldest();
        held_bytes = held_bytes - TOTAL_W'(age_list[0].size);
        void'(age_list.pop_front());
    endfunction

    // Apply one request to the cache image and return the result it causes
    function automatic lookup_result_t apply_request(input logic [KEY_FIELD_W-1:0] key,
                                                     input logic [BYTES_W-1:0] size);
        lookup_result_t res;
        held_obj_t      obj;
        int             found;
        res = '0;
        found = -1;
        foreach (age_list[i])
        begin
            if (age_list[i].key == key)
                found = i;
        end
        if (found >= 0)
        begin
            // Hit: move to the young end, nothing else changes
            res.hit = 1'b1;
            obj = age_list[found];
            age_list.delete(found);
            age_list.push_back(obj);
        end
        else
        begin
            if (size <= budget)
            begin
                // A full table gives up its oldest entry first
                if (age_list.size() >= ENTRIES)
                begin
                    drop_oldest();
                    res.evicted = res.evicted + 1'b1;
                end
                obj.key = key;
                obj.size = size;
                age_list.push_back(obj);
                held_bytes = held_bytes + TOTAL_W'(size);
                res.inserted = 1'b1;
            end
            // Evict down to the budget, which may have been lowered
            while (held_bytes > TOTAL_W'(budget) && age_list.size() > 0)
            begin
                drop_oldest();
                res.evicted = res.evicted + 1'b1;
            end
        end
        res.in_use = held_bytes[BYTES_W-1:0];
        return res;
    endfunction

    task automatic check_field(input string name, input logic [BYTES_W-1:0] want,
                               input logic [BYTES_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Track config writes, predict on each request, compare on each result
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        lookup_result_t due;
        if (!rst_n)
        begin
            age_list.delete();
            results_due.delete();
            budget = '0;
            held_bytes = '0;
            fail_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_wen)
                budget = cfg_wdata;
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result with no request waiting: %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    due = results_due.pop_front();
                    check_field("hit", BYTES_W'(due.hit), BYTES_W'(m_tdata[0]));
                    check_field("inserted", BYTES_W'(due.inserted), BYTES_W'(m_tdata[1]));
                    check_field("evicted_count", BYTES_W'(due.evicted),
                                BYTES_W'(m_tdata[6:2]));
                    check_field("bytes_in_use", due.in_use, m_tdata[38:7]);
                end
            end
            if (s_tvalid && s_tready)
                results_due.push_back(apply_request(s_tdata[KEY_FIELD_W-1:0],
                                                    s_tdata[S_TDATA_W-1:KEY_FIELD_W]));
            outstanding = results_due.size();
        end
    end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Top of the byte-budget LRU cache regression: clock, reset, request and
// config stimulus, receiver stalls, watchdog and verdict.
// Depends on bblru_pkg, byte_budget_lru_cache and bblru_result_monitor.
`default_nettype none

module testbench;
    import bblru_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES       = ENTRIES_DEF;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = ENTRIES + 14;
    localparam int LONG_HOLD     = 400;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 204;
    localparam int POOL_SIZE     = 24;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wen;
    logic [BYTES_W-1:0]   cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    int                   fail_count;
    int                   outstanding;
    int                   quiet_cycles = 0;
    int                   tx_idle_pct = 0;
    int                   rx_stall_pct = 0;
    bit                   hold_request = 1'b0;
    logic [BYTES_W-1:0]   budget_now = '0;
    logic [KEY_FIELD_W-1:0] key_pool[POOL_SIZE];

    byte_budget_lru_cache #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS_DEF)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    bblru_result_monitor #(
        .ENTRIES (ENTRIES)
    ) u_monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drive the result side: random stalls, or one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("byte_budget_lru_cache regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one request, with random gaps ahead of it, and wait for acceptance
    task automatic send_request(input logic [KEY_FIELD_W-1:0] key,
                                input logic [BYTES_W-1:0] size);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {size, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop offering and wait until every result is back and the block is quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_budget(input logic [BYTES_W-1:0] value);
        settle();
        cfg_wen    <= 1'b1;
        cfg_wdata  <= value;
        budget_now = value;
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    // Random requests: keys mostly from a small pool so hits and refills occur
    task automatic run_phase(input logic [BYTES_W-1:0] budget, input int tx_pct,
                             input int rx_pct, input bit long_hold);
        logic [KEY_FIELD_W-1:0] key;
        logic [BYTES_W-1:0]     size;
        int                     roll;
        write_budget(budget);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if (long_hold && n == 60)
                hold_request = 1'b1;
            if ($urandom_range(99) < 75)
                key = key_pool[$urandom_range(POOL_SIZE - 1)];
            else
                key = $urandom;
            roll = $urandom_range(99);
            if (roll < 8)
                size = '0;
            else if (roll < 12)
                size = budget_now;
            else if (roll < 15)
                size = budget_now + 1'b1;
            else if (roll < 22)
                size = $urandom;
            else if (roll < 45)
                size = $urandom_range(budget_now / 64);
            else
                size = $urandom_range(budget_now / 3);
            send_request(key, size);
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n     = 1'b0;
        cfg_wen   = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Zero budget after reset: zero-byte object fits, one byte does not
        send_request('0, '0);
        send_request('1, 32'd1);
        send_request('0, 32'd5);

        // Largest budget: largest object, then overflow evicts two
        write_budget('1);
        send_request(32'd1, '1);
        send_request(32'd2, 32'd1);

        // Fill the table; the seventeenth insert evicts on a full table
        write_budget(32'd100);
        for (int i = 0; i <= ENTRIES; i++)
            send_request(32'h100 + i, 32'd6);

        // Lower the budget: a hit stays over it, the next miss evicts down
        write_budget(32'd20);
        send_request(32'h108, '0);
        send_request(32'h8000_0000, 32'd50);
        send_request(32'h7FFF_FFFF, 32'd20);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0: run_phase(p == 0 ? 32'hFFFF_FFFF : $urandom, 0, 0, 1'b1);
                1: run_phase(p == 1 ? 32'd2000 : 32'd500, 76, 0, 1'b0);
                2: run_phase(p == 2 ? 32'd60 : 32'hFFFF_FFFF, 0, 76, 1'b0);
                default: run_phase(p == 3 ? 32'd0 : 32'd9000, 29, 29, 1'b0);
            endcase
        end

        settle();
        if (fail_count == 0 && outstanding == 0)
            $display("byte_budget_lru_cache regression: pass");
        else
            $display("byte_budget_lru_cache regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/bblru_pkg.sv
rtl/bblru_cell.sv
rtl/byte_budget_lru_cache.sv
sim/bblru_result_monitor.sv
sim/testbench.sv
